FILE: hdl/c2u_pkg.sv
// shared types, constants and the windows-1252 upper table for the transcoder
`default_nettype none

package c2u_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CpW = 21;

  localparam logic [CpW-1:0] QuestionMark  = 21'h00003F;
  localparam logic [CpW-1:0] SupplementBase = 21'h010000;

  typedef enum logic [1:0] {
    MODE_PASS      = 2'd0,
    MODE_CP1252    = 2'd1,
    MODE_UTF16_LE  = 2'd2,
    MODE_UTF16_BE  = 2'd3
  } c2u_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } c2u_in_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
  } c2u_out_t;

  // one queued result: a raw byte or a code point to encode
  typedef struct packed {
    logic           raw;
    logic [CpW-1:0] cp;
  } c2u_entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } c2u_qstat_t;

  function automatic logic [15:0] win1252_hi(input logic [4:0] idx);
    logic [15:0] cp;
    case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h008D;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h008F;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h009D;
      5'd30: cp = 16'h017E;
      default: cp = 16'h0178;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/c2u_front.sv
// input side: mode register, utf-16 pairing and code point selection
`default_nettype none

module c2u_front import c2u_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire c2u_in_t    in_data_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output c2u_entry_t      entry_o
);

  c2u_mode_e   mode_q;
  logic        phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [9:0]  hs_q, hs_d;
  logic        pend_q, pend_d;

  logic        accept;
  logic        push;
  logic [7:0]  b;
  logic [15:0] unit;
  logic        is_hi, is_lo;
  logic [CpW-1:0] pair_cp;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign b          = in_data_i.data_byte;
  assign unit       = (mode_q == MODE_UTF16_LE) ? {b, held_q} : {held_q, b};
  assign is_hi      = (unit[15:10] == 6'b110110);
  assign is_lo      = (unit[15:10] == 6'b110111);
  assign pair_cp    = SupplementBase + {1'b0, hs_q, unit[9:0]};

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    hs_d    = hs_q;
    pend_d  = pend_q;
    push    = 1'b0;
    entry_o = '0;
    case (mode_q)
      MODE_PASS: begin
        push         = 1'b1;
        entry_o.raw  = 1'b1;
        entry_o.cp   = {13'd0, b};
      end
      MODE_CP1252: begin
        push = 1'b1;
        if (b[7:5] == 3'b100) begin
          entry_o.cp = {5'd0, win1252_hi(b[4:0])};
        end else begin
          entry_o.cp = {13'd0, b};
        end
      end
      default: begin
        if (!phase_q) begin
          held_d  = b;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          held_d  = '0;
          if (pend_q) begin
            push       = 1'b1;
            entry_o.cp = is_lo ? pair_cp : QuestionMark;
            pend_d     = 1'b0;
            hs_d       = '0;
          end else if (is_hi) begin
            hs_d   = unit[9:0];
            pend_d = 1'b1;
          end else if (is_lo) begin
            push       = 1'b1;
            entry_o.cp = QuestionMark;
          end else begin
            push       = 1'b1;
            entry_o.cp = {5'd0, unit};
          end
        end
      end
    endcase
    if (in_data_i.end_of_stream) begin
      phase_d = 1'b0;
      held_d  = '0;
      hs_d    = '0;
      pend_d  = 1'b0;
    end
  end

  assign push_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PASS;
      phase_q <= 1'b0;
      held_q  <= '0;
      hs_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= c2u_mode_e'(cfg_wdata_i);
      end
      if (accept) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        hs_q    <= hs_d;
        pend_q  <= pend_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/c2u_queue.sv
// short result queue between the input and output sides
`default_nettype none

module c2u_queue import c2u_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire c2u_entry_t entry_i,
  input  wire logic       pop_i,
  output c2u_entry_t      head_o,
  output c2u_qstat_t      stat_o
);

  c2u_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]       count_q, count_d;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] n;
    if (p == QPtrW'(QDepth - 1)) begin
      n = '0;
    end else begin
      n = p + QPtrW'(1);
    end
    return n;
  endfunction

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.full      = (count_q == QCntW'(QDepth));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/c2u_back.sv
// output side: utf-8 byte serialiser with registered output
`default_nettype none

module c2u_back import c2u_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire c2u_entry_t head_i,
  input  wire c2u_qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output c2u_out_t        out_data_o
);

  logic           out_valid_q;
  c2u_out_t       out_data_q;
  logic [1:0]     idx_q;
  logic [1:0]     last_idx;
  logic [1:0]     remain;
  logic [7:0]     byte_val;
  logic           last;
  logic           load;
  logic [CpW-1:0] cp;

  assign cp = head_i.cp;

  always_comb begin
    if (head_i.raw || cp < 21'h000080) begin
      last_idx = 2'd0;
    end else if (cp < 21'h000800) begin
      last_idx = 2'd1;
    end else if (cp < 21'h010000) begin
      last_idx = 2'd2;
    end else begin
      last_idx = 2'd3;
    end
  end

  assign remain = last_idx - idx_q;
  assign last   = (idx_q == last_idx);

  always_comb begin
    if (idx_q == 2'd0) begin
      case (last_idx)
        2'd0:    byte_val = cp[7:0];
        2'd1:    byte_val = {3'b110, cp[10:6]};
        2'd2:    byte_val = {4'b1110, cp[15:12]};
        default: byte_val = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (remain)
        2'd0:    byte_val = {2'b10, cp[5:0]};
        2'd1:    byte_val = {2'b10, cp[11:6]};
        default: byte_val = {2'b10, cp[17:12]};
      endcase
    end
  end

  assign load        = qstat_i.not_empty && (!out_valid_q || !out_stall_i);
  assign pop_o       = load && last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.utf8_byte <= byte_val;
      out_data_q.run_last  <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/charset_to_utf8_transcoder.sv
// top level: charset to utf-8 transcoder
// path: a result is written into the queue and then loaded into the output register
// throughput: one input byte per cycle while the two-entry queue has room;
// the output register gives one utf-8 byte per cycle unless out_stall_i is set;
// a code point of 1 to 4 utf-8 bytes holds the queue head until its last loads
// reset: asynchronous, clears mode to passthrough, utf-16 state, queue and output
`default_nettype none

module charset_to_utf8_transcoder import c2u_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire c2u_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output c2u_out_t        out_data_o
);

  logic       push;
  logic       pop;
  c2u_entry_t entry;
  c2u_entry_t head;
  c2u_qstat_t qstat;

  c2u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (qstat.full),
    .push_o      (push),
    .entry_o     (entry)
  );

  c2u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  c2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // no write into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full))
    else $error("push into full queue");

  // a multi-byte sequence continues without a gap
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_last) |=> out_valid_o)
    else $error("gap inside a utf-8 sequence");

  // output drains when the queue is empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !qstat.not_empty) |=> !out_valid_o)
    else $error("output valid without queued data");

  // nothing is popped from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.not_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: verif/c2u_checker.sv
// checker for the charset to utf-8 transcoder: tracks config, predicts utf-8 bytes, compares
module c2u_checker import c2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  c2u_in_t    in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  c2u_out_t   out_data_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // windows-1252 code points for bytes 0x80 to 0x9f, entry 0 in the low bits
  localparam logic [32*16-1:0] Win1252Upper = {
    16'h0178, 16'h017E, 16'h009D, 16'h0153, 16'h203A, 16'h0161, 16'h2122, 16'h02DC,
    16'h2014, 16'h2013, 16'h2022, 16'h201D, 16'h201C, 16'h2019, 16'h2018, 16'h0090,
    16'h008F, 16'h017D, 16'h008D, 16'h0152, 16'h2039, 16'h0160, 16'h2030, 16'h02C6,
    16'h2021, 16'h2020, 16'h2026, 16'h201E, 16'h0192, 16'h201A, 16'h0081, 16'h20AC
  };

  c2u_mode_e   mode_q = MODE_PASS;
  logic        unit_half_q;
  logic [7:0]  held_byte_q;
  logic [15:0] high_surrogate_q;
  logic        surrogate_waiting_q;
  c2u_out_t    utf8_expected_q[$];
  int          fails = 0;

  task automatic push_utf8(input logic [7:0] b);
    c2u_out_t e;
    e.utf8_byte = b;
    e.run_last  = 1'b0;
    utf8_expected_q.push_back(e);
  endtask

  task automatic encode_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_utf8(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_utf8({3'b110, cp[10:6]});
      push_utf8({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_utf8({4'b1110, cp[15:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end else begin
      push_utf8({5'b11110, cp[20:18]});
      push_utf8({2'b10, cp[17:12]});
      push_utf8({2'b10, cp[11:6]});
      push_utf8({2'b10, cp[5:0]});
    end
  endtask

  task automatic clear_stream_state();
    unit_half_q         = 1'b0;
    held_byte_q         = '0;
    high_surrogate_q    = '0;
    surrogate_waiting_q = 1'b0;
  endtask

  task automatic transcode_byte(input c2u_in_t item);
    logic [15:0] unit;
    logic [7:0]  b;
    int          start_len;
    c2u_out_t    tail;
    b = item.data_byte;
    start_len = utf8_expected_q.size();
    case (mode_q)
      MODE_PASS: begin
        push_utf8(b);
      end
      MODE_CP1252: begin
        if (b[7:5] == 3'b100) encode_code_point({5'd0, Win1252Upper[b[4:0]*16 +: 16]});
        else encode_code_point({13'd0, b});
      end
      default: begin
        if (!unit_half_q) begin
          held_byte_q = b;
          unit_half_q = 1'b1;
        end else begin
          unit_half_q = 1'b0;
          unit = (mode_q == MODE_UTF16_LE) ? {b, held_byte_q} : {held_byte_q, b};
          held_byte_q = '0;
          if (surrogate_waiting_q) begin
            if (unit[15:10] == 6'b110111)
              encode_code_point(21'h10000 + {1'b0, high_surrogate_q[9:0], unit[9:0]});
            else
              push_utf8(8'h3F);
            surrogate_waiting_q = 1'b0;
            high_surrogate_q    = '0;
          end else if (unit[15:10] == 6'b110110) begin
            high_surrogate_q    = unit;
            surrogate_waiting_q = 1'b1;
          end else if (unit[15:10] == 6'b110111) begin
            push_utf8(8'h3F);
          end else begin
            encode_code_point({5'd0, unit});
          end
        end
      end
    endcase
    if (item.end_of_stream) clear_stream_state();
    if (utf8_expected_q.size() > start_len) begin
      tail = utf8_expected_q[utf8_expected_q.size()-1];
      void'(utf8_expected_q.pop_back());
      tail.run_last = 1'b1;
      utf8_expected_q.push_back(tail);
    end
  endtask

  task automatic check_utf8(input c2u_out_t got);
    c2u_out_t want;
    if (utf8_expected_q.size() == 0) begin
      $display("%0t: utf8 transfer expected none, actual byte %02h last %b",
               $realtime, got.utf8_byte, got.run_last);
      fails++;
    end else begin
      want = utf8_expected_q.pop_front();
      if (got.utf8_byte !== want.utf8_byte) begin
        $display("%0t: utf8_byte expected %02h, actual %02h",
                 $realtime, want.utf8_byte, got.utf8_byte);
        fails++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last expected %b, actual %b", $realtime, want.run_last, got.run_last);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_PASS;
      clear_stream_state();
      utf8_expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) mode_q = c2u_mode_e'(cfg_wdata_i);
      if (in_valid_i && !in_stall_i) transcode_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_utf8(out_data_i);
      pending_o    <= utf8_expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: verif/tb_charset_to_utf8_transcoder.sv
// testbench top for the charset to utf-8 transcoder: clock, reset, stimulus and verdict
module tb_charset_to_utf8_transcoder import c2u_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  c2u_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  c2u_out_t   out_data;
  int         fail_count;
  int         pending;

  c2u_mode_e  cur_mode  = MODE_PASS;
  int         bytes_sent = 0;
  bit         idle_on    = 1'b1;
  bit         stall_on   = 1'b1;

  charset_to_utf8_transcoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  c2u_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("charset_to_utf8_transcoder: mismatch");
    $finish;
  end

  // random stall bursts on the utf-8 side
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_stream: eos};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_unit(input logic [15:0] u, input logic eos);
    if (cur_mode == MODE_UTF16_LE) begin
      send_byte(u[7:0], 1'b0);
      send_byte(u[15:8], eos);
    end else begin
      send_byte(u[15:8], 1'b0);
      send_byte(u[7:0], eos);
    end
  endtask

  // only once the transcoder has drained
  task automatic set_mode(input c2u_mode_e m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    cur_mode   = m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_utf16_piece();
    logic [15:0] u;
    logic        eos;
    int          kind;
    kind = $urandom_range(0, 9);
    eos  = ($urandom_range(0, 7) == 0);
    u    = 16'($urandom_range(0, 16'hFFFF));
    case (kind)
      0, 1, 2: send_unit(16'($urandom_range(0, 16'h7F)), eos);
      3, 4: begin
        if (u[15:11] == 5'b11011) u[14] = 1'b0;
        send_unit(u, eos);
      end
      5, 6: begin
        send_unit(16'hD800 + 16'($urandom_range(0, 16'h3FF)), 1'b0);
        send_unit(16'hDC00 + 16'($urandom_range(0, 16'h3FF)), eos);
      end
      7: send_unit(16'hDC00 + 16'($urandom_range(0, 16'h3FF)), eos);
      8: begin
        send_unit(16'hD800 + 16'($urandom_range(0, 16'h3FF)), 1'b0);
        if (u[15:10] == 6'b110111) u = u - 16'h400;
        send_unit(u, eos);
      end
      default: send_byte(u[7:0], eos);
    endcase
  endtask

  initial begin
    int phase_end;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    set_mode(MODE_CP1252);
    send_byte(8'h80, 1'b0);
    send_byte(8'h8D, 1'b0);
    send_byte(8'hFF, 1'b1);

    set_mode(MODE_UTF16_LE);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_byte(8'h41, 1'b1);
    send_unit(16'hDBFF, 1'b1);

    set_mode(MODE_UTF16_BE);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    // half a unit carried across a mode change
    send_byte(8'h00, 1'b0);
    set_mode(MODE_UTF16_LE);
    send_byte(8'h41, 1'b1);

    while (bytes_sent < 136) begin
      set_mode(c2u_mode_e'($urandom_range(0, 3)));
      phase_end = bytes_sent + $urandom_range(8, 24);
      while (bytes_sent < phase_end) begin
        if (bytes_sent >= 110) begin
          idle_on  = 1'b0;
          stall_on = 1'b0;
        end
        if (cur_mode == MODE_UTF16_LE || cur_mode == MODE_UTF16_BE)
          send_utf16_piece();
        else
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("charset_to_utf8_transcoder: match");
    end else begin
      $display("charset_to_utf8_transcoder: mismatch");
    end
    $finish;
  end

endmodule
